/* hdl/rgbhsv_pkg.sv */
// Shared constants and pipeline word type for the RGB to HSV converter.
package rgbhsv_pkg;

	localparam int PIX_W    = 8;
	localparam int HUE_W    = 15;
	localparam int SAT_W    = 17;
	localparam int DEN_W    = PIX_W + 1;
	localparam int REM_W    = 25;
	localparam int DIV_BITS = 17;
	localparam int DIV_BPS  = 2;
	localparam int DIV_STAGES = (DIV_BITS + DIV_BPS - 1) / DIV_BPS;
	localparam int QIDX_W   = $clog2(DIV_BITS);

	localparam logic [DIV_BITS-1:0] HUE_TURN = DIV_BITS'(23040);

	// k factor of the hue sector, times the chroma, added to the channel difference
	localparam logic [2:0] K_RED      = 3'd0;
	localparam logic [2:0] K_RED_WRAP = 3'd6;
	localparam logic [2:0] K_GREEN    = 3'd2;
	localparam logic [2:0] K_BLUE     = 3'd4;

	typedef struct packed {
		logic [REM_W-1:0]    rem_h;
		logic [REM_W-1:0]    rem_s;
		logic [DEN_W-1:0]    den_h;
		logic [DEN_W-1:0]    den_s;
		logic [DIV_BITS-1:0] quo_h;
		logic [DIV_BITS-1:0] quo_s;
		logic [PIX_W-1:0]    mx;
		logic                grey;
	} div_word_t;

endpackage

/* hdl/rgbhsv_pix_if.sv */
// Pixel input channel: valid/ready handshake with RGB payload.
interface rgbhsv_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rgbhsv_pkg::PIX_W-1:0] red;
	logic [rgbhsv_pkg::PIX_W-1:0] green;
	logic [rgbhsv_pkg::PIX_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/rgbhsv_hsv_if.sv */
// HSV result channel: valid/ready handshake with hue, saturation and value payload.
interface rgbhsv_hsv_if;
	logic                        valid;
	logic                        ready;
	logic [rgbhsv_pkg::HUE_W-1:0] hue;
	logic [rgbhsv_pkg::SAT_W-1:0] saturation;
	logic [rgbhsv_pkg::PIX_W-1:0] value_level;

	modport source (output valid, output hue, output saturation, output value_level,
		input ready);
	modport sink   (input valid, input hue, input saturation, input value_level,
		output ready);
endinterface

/* hdl/rgb_to_hsv_converter_core.sv */
// RGB to HSV converter core: pipelined max/min, sector select and two long dividers.
//
//  channel | dir | word
//  pixel   | in  | red, green, blue (8b each)
//  hsv     | out | hue (15b, 1/64 deg), saturation (17b, Q1.16), value_level (8b)
//
// One word per cycle while hsv does not stall; stages are s1 max/min, s2 numerators, 9 divider
// stages at 2 quotient bits each, and the output stage.
// Latency is set by the restoring dividers for hue and saturation.
// arst_n clears all valid bits; payload registers are not reset.
// A stall at hsv fills bubbles first, then holds the pipe; pixel.ready drops
// only when every stage holds a word.
module rgb_to_hsv_converter_core (
	input  logic                clk,
	input  logic                arst_n,
	rgbhsv_pix_if.sink          pixel,
	rgbhsv_hsv_if.source        hsv
);

	localparam int NS = rgbhsv_pkg::DIV_STAGES;

	// stage enables
	logic          en_s1;
	logic [NS:0]   en_div;
	logic          en_s12;

	// s1: max, chroma, sector
	logic                          v_s1;
	logic [rgbhsv_pkg::PIX_W-1:0]  mx_s1;
	logic [rgbhsv_pkg::PIX_W-1:0]  c_s1;
	logic signed [rgbhsv_pkg::PIX_W:0] d_s1;
	logic [2:0]                    k_s1;

	// div_s[j] is pipeline stage j+2
	logic [NS:0]             div_v;
	rgbhsv_pkg::div_word_t   div_s  [NS+1];
	rgbhsv_pkg::div_word_t   div_nx [NS];

	// s12: output stage
	logic                          v_s12;
	logic [rgbhsv_pkg::HUE_W-1:0]  hue_s12;
	logic [rgbhsv_pkg::SAT_W-1:0]  sat_s12;
	logic [rgbhsv_pkg::PIX_W-1:0]  val_s12;

	always_comb begin
		en_s12 = !v_s12 || hsv.ready;
		en_div[NS] = !div_v[NS] || en_s12;
		for (int j = NS - 1; j >= 0; j--) begin
			en_div[j] = !div_v[j] || en_div[j+1];
		end
		en_s1 = !v_s1 || en_div[0];
	end

	assign pixel.ready = en_s1;

	// s1 logic
	logic [rgbhsv_pkg::PIX_W-1:0]      mx_c, mn_c;
	logic signed [rgbhsv_pkg::PIX_W:0] d_c;
	logic [2:0]                        k_c;

	always_comb begin
		mx_c = pixel.red;
		mn_c = pixel.red;
		if (pixel.green > mx_c) mx_c = pixel.green;
		if (pixel.blue > mx_c) mx_c = pixel.blue;
		if (pixel.green < mn_c) mn_c = pixel.green;
		if (pixel.blue < mn_c) mn_c = pixel.blue;
		priority if (mx_c == pixel.red) begin
			d_c = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
			k_c = d_c[rgbhsv_pkg::PIX_W] ? rgbhsv_pkg::K_RED_WRAP : rgbhsv_pkg::K_RED;
		end else if (mx_c == pixel.green) begin
			d_c = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
			k_c = rgbhsv_pkg::K_GREEN;
		end else begin
			d_c = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
			k_c = rgbhsv_pkg::K_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1 <= mx_c;
			c_s1  <= mx_c - mn_c;
			d_s1  <= d_c;
			k_s1  <= k_c;
		end
	end

	// s2 logic: hue numerator 2*3840*(k*c+d) + c, saturation numerator 2*65536*c + max
	logic signed [11:0]            t_sgn;
	logic [10:0]                   t_c;
	rgbhsv_pkg::div_word_t         w2_c;

	always_comb begin
		t_sgn = $signed({1'b0, 11'(k_s1) * 11'(c_s1)}) + 12'(d_s1);
		t_c   = t_sgn[10:0];
		w2_c.rem_h = (rgbhsv_pkg::REM_W'(t_c) << 13) - (rgbhsv_pkg::REM_W'(t_c) << 9)
			+ rgbhsv_pkg::REM_W'(c_s1);
		w2_c.rem_s = (rgbhsv_pkg::REM_W'(c_s1) << 17) + rgbhsv_pkg::REM_W'(mx_s1);
		w2_c.den_h = {c_s1, 1'b0};
		w2_c.den_s = {mx_s1, 1'b0};
		w2_c.quo_h = '0;
		w2_c.quo_s = '0;
		w2_c.mx    = mx_s1;
		w2_c.grey  = (c_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else if (en_div[0]) begin
			div_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_div[0]) begin
			div_s[0] <= w2_c;
		end
	end

	// restoring divider stages, DIV_BPS quotient bits each
	for (genvar j = 0; j < NS; j++) begin : g_div
		always_comb begin
			rgbhsv_pkg::div_word_t        w;
			logic [rgbhsv_pkg::REM_W:0]   dsh;
			int                           sh;
			w = div_s[j];
			for (int b = 0; b < rgbhsv_pkg::DIV_BPS; b++) begin
				sh = rgbhsv_pkg::DIV_BITS - 1 - (j * rgbhsv_pkg::DIV_BPS + b);
				if (sh >= 0) begin
					dsh = (rgbhsv_pkg::REM_W + 1)'(w.den_h) << sh[rgbhsv_pkg::QIDX_W-1:0];
					if ({1'b0, w.rem_h} >= dsh) begin
						w.rem_h = w.rem_h - dsh[rgbhsv_pkg::REM_W-1:0];
						w.quo_h[sh[rgbhsv_pkg::QIDX_W-1:0]] = 1'b1;
					end
					dsh = (rgbhsv_pkg::REM_W + 1)'(w.den_s) << sh[rgbhsv_pkg::QIDX_W-1:0];
					if ({1'b0, w.rem_s} >= dsh) begin
						w.rem_s = w.rem_s - dsh[rgbhsv_pkg::REM_W-1:0];
						w.quo_s[sh[rgbhsv_pkg::QIDX_W-1:0]] = 1'b1;
					end
				end
			end
			div_nx[j] = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[j+1] <= 1'b0;
			end else if (en_div[j+1]) begin
				div_v[j+1] <= div_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en_div[j+1]) begin
				div_s[j+1] <= div_nx[j];
			end
		end
	end

	// output stage: wrap a rounded full turn, zero the grey case
	logic [rgbhsv_pkg::DIV_BITS-1:0] hue_c;

	always_comb begin
		hue_c = div_s[NS].quo_h;
		if (hue_c >= rgbhsv_pkg::HUE_TURN) hue_c = hue_c - rgbhsv_pkg::HUE_TURN;
		if (div_s[NS].grey) hue_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en_s12) begin
			v_s12 <= div_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s12) begin
			hue_s12 <= hue_c[rgbhsv_pkg::HUE_W-1:0];
			sat_s12 <= div_s[NS].grey ? '0 : div_s[NS].quo_s[rgbhsv_pkg::SAT_W-1:0];
			val_s12 <= div_s[NS].mx;
		end
	end

	assign hsv.valid       = v_s12;
	assign hsv.hue         = hue_s12;
	assign hsv.saturation  = sat_s12;
	assign hsv.value_level = val_s12;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> (rgbhsv_pkg::DIV_BITS'(hsv.hue) < rgbhsv_pkg::HUE_TURN))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> (hsv.saturation <= rgbhsv_pkg::SAT_W'(65536)))
		else $error("saturation above one");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv.valid && hsv.value_level == '0) |-> (hsv.saturation == '0 && hsv.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v_s1)
		else $error("accepted word not captured in first stage");

endmodule

/* bench/tb_rgb_to_hsv_converter_core.sv */
// Testbench for rgb_to_hsv_converter_core: directed, random and back-pressure pixel streams.
module tb_rgb_to_hsv_converter_core;

	localparam int PIX_W        = rgbhsv_pkg::PIX_W;
	localparam int HUE_W        = rgbhsv_pkg::HUE_W;
	localparam int SAT_W        = rgbhsv_pkg::SAT_W;
	localparam int SECTOR_UNITS = 3840;
	localparam int FULL_TURN    = 23040;
	localparam int SAT_ONE      = 65536;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 60;
	localparam int TAIL_CYCLES  = 20;
	localparam int PHASE_WORDS  = 195;
	localparam int EXP_DEPTH    = 1024;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [PIX_W-1:0] value_level;
	} hsv_word_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	bit   clk = 1'b0;
	logic arst_n;

	rgbhsv_pix_if pix_ch ();
	rgbhsv_hsv_if hsv_ch ();

	rgb_to_hsv_converter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_ch),
		.hsv    (hsv_ch)
	);

	hsv_word_t exp_mem [EXP_DEPTH];
	int        exp_wr = 0;
	int        exp_rd = 0;
	int        bad_words = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	bit        gapless = 1'b0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;
	int        pat_idx = 0;
	rx_mode_t  rx_mode = RX_ALWAYS;
	logic [15:0] stall_pattern = 16'b1101_0011_1011_0110;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic hsv_word_t hsv_of_pixel(input logic [PIX_W-1:0] r, g, b);
		int ri, gi, bi, mx, mn, c, d, k, h, s;
		hsv_word_t res;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		c = mx - mn;
		h = 0;
		s = 0;
		if (c != 0) begin
			if (mx == ri) begin
				d = gi - bi;
				k = (d < 0) ? int'(rgbhsv_pkg::K_RED_WRAP) : int'(rgbhsv_pkg::K_RED);
			end else if (mx == gi) begin
				d = bi - ri;
				k = int'(rgbhsv_pkg::K_GREEN);
			end else begin
				d = ri - gi;
				k = int'(rgbhsv_pkg::K_BLUE);
			end
			h = (2 * SECTOR_UNITS * (k * c + d) + c) / (2 * c);
			if (h >= FULL_TURN)
				h -= FULL_TURN;
		end
		if (mx != 0)
			s = (2 * c * SAT_ONE + mx) / (2 * mx);
		res.hue         = HUE_W'(h);
		res.saturation  = SAT_W'(s);
		res.value_level = PIX_W'(mx);
		return res;
	endfunction

	// mix of grey, tied maxima, near-black and uniform pixels
	function automatic logic [3*PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] m, o;
		int kind;
		kind = $urandom_range(0, 9);
		m = 8'($urandom_range(1, 255));
		o = 8'($urandom_range(0, m - 1));
		unique case (kind)
			0: return {m, m, m};
			1: return {m, m, o};
			2: return {m, o, m};
			3: return {o, m, m};
			4: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3))};
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
		@(negedge clk);
		if (!gapless && burst_left == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0)
			burst_left--;
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= r;
		pix_ch.green <= g;
		pix_ch.blue  <= b;
		do @(posedge clk); while (!pix_ch.ready);
		exp_mem[exp_wr % EXP_DEPTH] = hsv_of_pixel(r, g, b);
		exp_wr++;
	endtask

	task automatic finish_stream();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
	endtask

	task automatic test_directed();
		gapless = 1'b0;
		rx_mode = RX_RANDOM;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd1);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd255);
		send_pixel(8'd0, 8'd1, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd3, 8'd1, 8'd2);
		send_pixel(8'd2, 8'd3, 8'd1);
		send_pixel(8'd254, 8'd1, 8'd127);
		send_pixel(8'h55, 8'hAA, 8'h0F);
		send_pixel(8'hF0, 8'h33, 8'hCC);
		finish_stream();
	endtask

	task automatic test_random();
		logic [3*PIX_W-1:0] px;
		for (int phase = 0; phase < 4; phase++) begin
			gapless = (phase == 0 || phase == 3);
			rx_mode = (phase == 0) ? RX_ALWAYS : (phase == 2) ? RX_PATTERN : RX_RANDOM;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				px = random_pixel();
				send_pixel(px[23:16], px[15:8], px[7:0]);
			end
		end
		finish_stream();
	endtask

	task automatic test_back_pressure();
		logic [3*PIX_W-1:0] px;
		gapless = 1'b1;
		rx_mode = RX_ALWAYS;
		hold_req = 1'b1;
		for (int i = 0; i < 48; i++) begin
			px = random_pixel();
			send_pixel(px[23:16], px[15:8], px[7:0]);
		end
		finish_stream();
	endtask

	initial begin
		hsv_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hsv_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				unique case (rx_mode)
					RX_ALWAYS: hsv_ch.ready <= 1'b1;
					RX_RANDOM: hsv_ch.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						hsv_ch.ready <= stall_pattern[pat_idx];
						pat_idx = (pat_idx + 1) % 16;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		hsv_word_t want, got;
		if (arst_n && hsv_ch.valid && hsv_ch.ready) begin
			got.hue         = hsv_ch.hue;
			got.saturation  = hsv_ch.saturation;
			got.value_level = hsv_ch.value_level;
			if (exp_wr == exp_rd) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected word: hue %0d sat %0d val %0d",
						got.hue, got.saturation, got.value_level);
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got.hue !== want.hue || got.saturation !== want.saturation ||
						got.value_level !== want.value_level) begin
					bad_words++;
					if (bad_words <= 10)
						$display({"mismatch: exp hue %0d sat %0d val %0d, ",
							"got hue %0d sat %0d val %0d"},
							want.hue, want.saturation, want.value_level,
							got.hue, got.saturation, got.value_level);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (hsv_ch.valid && hsv_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		test_back_pressure();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_words == 0 && exp_wr == exp_rd) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/rgbhsv_pkg.sv
hdl/rgbhsv_pix_if.sv
hdl/rgbhsv_hsv_if.sv
hdl/rgb_to_hsv_converter_core.sv
bench/tb_rgb_to_hsv_converter_core.sv
